[src/paot_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access order tracker package
// Widths, register indexes, sweep mode codes and record bit positions.
// ----------------------------------------------------------------------------
package paot_pkg;

    localparam int MAX_PAGES_DEF = 65536;

    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 36;
    localparam int CNT_W      = 17;
    localparam int GRANT_W    = 32;
    localparam int REC_W      = 3;
    localparam int MODE_W     = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 36;

    // fault_address, wants_exec, wants_write -> 50 bits, padded to 56
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;
    // handled, was_written, was_executed, write_first, report, grant_total
    // -> 37 bits, padded to 40
    localparam int M_TDATA_W  = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd2;

    // Sweep modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXEC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd3;

    // Request commands
    localparam logic CMD_FAULT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Record bit positions
    localparam int REC_WRITTEN  = 0;
    localparam int REC_EXECUTED = 1;
    localparam int REC_WFIRST   = 2;

endpackage

[src/page_access_order_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page access order tracker
// Keeps a three-bit access record per page of the swept range in a RAM and
// grants execute or write permission on matching faults.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while m_axis_tready does not stall; the record RAM
//   is read on acceptance and written back in stage 1, with the last write forwarded to
//   a following request on the same page.
// Reset: synchronous, active low; clears registers and grant count, then runs
//   a clearing pass over all MAX_PAGES entries of the record RAM, one entry a cycle,
//   during which s_axis_tready stays low (configuration writes are still taken).
module page_access_order_tracker_unit #(
    parameter int MAX_PAGES = paot_pkg::MAX_PAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [paot_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [paot_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [47:0] fault_address, [48] wants_exec, [49] wants_write, [55:50] zero
    input  logic [paot_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] cmd
    input  logic [paot_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] handled, [1] was_written, [2] was_executed, [3] write_first,
    // [4] report, [36:5] grant_total, [39:37] zero
    output logic [paot_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import paot_pkg::*;

    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam logic [CNT_W-1:0] MaxCnt =
        (MAX_PAGES > (2**CNT_W - 1)) ? {CNT_W{1'b1}} : CNT_W'(MAX_PAGES);
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_PAGES - 1);

    // configuration registers
    logic [MODE_W-1:0]  r_sweep_mode;
    logic [PAGE_W-1:0]  r_base_page;
    logic [CNT_W-1:0]   r_page_count;

    // clearing pass
    logic               r_clr_busy;
    logic [IDX_W-1:0]   r_clr_addr;

    // request decode
    logic               in_acc;
    logic [PAGE_W-1:0]  in_page;
    logic [PAGE_W:0]    in_diff;
    logic [CNT_W-1:0]   eff_cnt;
    logic               in_range;
    logic [IDX_W-1:0]   in_idx;

    // stage 1
    logic               r_s1_valid;
    logic               r_s1_cmd;
    logic               r_s1_inr;
    logic               r_s1_wx;
    logic               r_s1_ww;
    logic [IDX_W-1:0]   r_s1_idx;
    logic               adv1;

    // forwarding of the last record write
    logic               r_fwd_valid;
    logic [IDX_W-1:0]   r_fwd_idx;
    logic [REC_W-1:0]   r_fwd_data;

    logic [REC_W-1:0]   ram_rdata;
    logic [REC_W-1:0]   rec_cur;
    logic [REC_W-1:0]   n_rec;
    logic               mode_match;
    logic               hit;
    logic               grant_x;
    logic               grant_w;
    logic               grant;
    logic               n_report;
    logic               item_we;
    logic [REC_W-1:0]   item_wdata;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [REC_W-1:0]   ram_wdata;

    logic [GRANT_W-1:0] r_grant_count;
    logic [GRANT_W-1:0] n_grant_count;

    // output register
    logic               r_out_valid;
    logic               r_out_handled;
    logic [REC_W-1:0]   r_out_rec;
    logic               r_out_report;
    logic [GRANT_W-1:0] r_out_grant;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_mode <= MODE_OFF;
            r_base_page  <= '0;
            r_page_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SWEEP_MODE: r_sweep_mode <= i_cfg_data[MODE_W-1:0];
                CFG_BASE_PAGE:  r_base_page  <= i_cfg_data[PAGE_W-1:0];
                CFG_PAGE_COUNT: r_page_count <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // clearing pass after reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LastIdx) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: range check and record read
    // ------------------------------------------------------------------
    assign adv1          = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || adv1);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign in_page  = s_axis_tdata[ADDR_W-1:PAGE_SHIFT];
    assign in_diff  = {1'b0, in_page} - {1'b0, r_base_page};
    assign eff_cnt  = (r_page_count > MaxCnt) ? MaxCnt : r_page_count;
    // a set top bit is a borrow: page below the base
    assign in_range = !in_diff[PAGE_W] && (in_diff[PAGE_W-1:0] < PAGE_W'(eff_cnt));
    assign in_idx   = in_diff[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (adv1) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd <= s_axis_tuser[0];
            r_s1_inr <= in_range;
            r_s1_wx  <= s_axis_tdata[ADDR_W];
            r_s1_ww  <= s_axis_tdata[ADDR_W+1];
            r_s1_idx <= in_idx;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: modify and write back
    // ------------------------------------------------------------------
    always_comb begin
        rec_cur = ram_rdata;
        // the RAM read may have coincided with the previous write
        if (r_fwd_valid && (r_fwd_idx == r_s1_idx)) begin
            rec_cur = r_fwd_data;
        end

        case (r_sweep_mode)
            MODE_EXEC:  mode_match = r_s1_wx;
            MODE_WRITE: mode_match = r_s1_ww;
            MODE_BOTH:  mode_match = r_s1_wx || r_s1_ww;
            default:    mode_match = 1'b0;
        endcase

        hit     = (r_s1_cmd == CMD_FAULT) && mode_match && r_s1_inr;
        grant_x = r_s1_wx && r_sweep_mode[0] && !rec_cur[REC_EXECUTED];
        grant_w = !grant_x && r_s1_ww && r_sweep_mode[1] && !rec_cur[REC_WRITTEN];
        grant   = hit && (grant_x || grant_w);

        n_rec = rec_cur;
        if (grant_x) begin
            n_rec[REC_EXECUTED] = 1'b1;
            n_rec[REC_WFIRST]   = rec_cur[REC_WFIRST] | rec_cur[REC_WRITTEN];
        end else if (grant_w) begin
            n_rec[REC_WRITTEN] = 1'b1;
        end

        n_report = grant && ((r_sweep_mode != MODE_BOTH) || n_rec[REC_WFIRST]);

        n_grant_count = r_grant_count;
        if (grant && (r_grant_count != {GRANT_W{1'b1}})) begin
            n_grant_count = r_grant_count + 1'b1;
        end

        item_we    = adv1 && (grant || ((r_s1_cmd == CMD_CLEAR) && r_s1_inr));
        item_wdata = (r_s1_cmd == CMD_CLEAR) ? '0 : n_rec;
    end

    assign ram_we    = r_clr_busy || item_we;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_idx;
    assign ram_wdata = r_clr_busy ? '0 : item_wdata;

    paot_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_PAGES)
    ) u_record_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (item_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            r_fwd_idx  <= r_s1_idx;
            r_fwd_data <= item_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grant_count <= '0;
        end else if (adv1) begin
            r_grant_count <= n_grant_count;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv1) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_out_handled <= hit;
            r_out_rec     <= hit ? n_rec : '0;
            r_out_report  <= n_report;
            r_out_grant   <= n_grant_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        (M_TDATA_W - GRANT_W - 5)'(0),
        r_out_grant,
        r_out_report,
        r_out_rec[REC_WFIRST],
        r_out_rec[REC_EXECUTED],
        r_out_rec[REC_WRITTEN],
        r_out_handled
    };

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_req_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!s_axis_tready && !r_s1_valid && !r_out_valid))
        else $error("request pipeline active during clearing pass");

    a_grant_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_grant_count >= $past(r_grant_count)))
        else $error("grant count decreased");

    a_grant_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_grant_count - $past(r_grant_count)) <= GRANT_W'(1)))
        else $error("grant count advanced by more than one");

    a_report_needs_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && n_report) |-> (hit && item_we))
        else $error("report raised without a recorded grant");

endmodule

[src/paot_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module paot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
